// ----- rtl/core/cws_pkg.sv -----
// Shared constants, register map and calendar helper functions for the wake scheduler.
`default_nettype none

package cws_pkg;

  // Register map: word index on the configuration port
  typedef enum logic [1:0] {
    REG_CADENCE    = 2'd0,
    REG_DESK_START = 2'd1,
    REG_DESK_END   = 2'd2,
    REG_SPARE      = 2'd3
  } cws_reg_e;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned DelayW  = 17;
  localparam int unsigned ElapsW  = 17;
  localparam int unsigned MsW     = 12;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [YearW-1:0]  YearFirst   = 12'd2024;
  localparam logic [YearW-1:0]  YearLast    = 12'd2099;
  localparam logic [17:0]       SecsPerDay  = 18'd86400;
  localparam logic [17:0]       SecsPerHour = 18'd3600;
  localparam logic [17:0]       WakeMargin  = 18'd5;

  localparam logic              CadenceRst   = 1'b0;
  localparam logic [HourW-1:0]  DeskStartRst = 5'd7;
  localparam logic [HourW-1:0]  DeskEndRst   = 5'd19;

  // Month length; leap selects 29 days for February
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Weekday offset per month for the table method
  function automatic logic [2:0] month_offset(input logic [MonthW-1:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

  // Remainder by 7: eight is one modulo seven, so fold octal digits
  function automatic logic [2:0] mod7_12(input logic [11:0] x);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
    t = 4'(s[4:3]) + 4'(s[2:0]);
    return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/calendar_wake_schedule.sv -----
// Top level: three-stage pipeline that checks a date-time and derives the wake schedule.
//
//  channel   ports                                   flow
//  --------  --------------------------------------  ---------------------------------
//  command   start, busy, year_i .. seconds_i         word taken when start && !busy
//  result    done_o, date_ok_o .. wake_delay_seconds_o one-cycle strobe on done_o
//  config    psel, penable, pwrite, paddr, pwdata,    APB, zero wait states
//            prdata, pready
//
//  A word may be issued every cycle; busy stays low.
//  Each result passes through the input stage, the date stage and the delay stage,
//  and results appear in issue order.
//  Reset clears the valid bits and loads the register defaults; no clearing pass.
//  The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module calendar_wake_schedule (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [cws_pkg::YearW-1:0]   year_i,
  input  wire logic [cws_pkg::MonthW-1:0]  month_i,
  input  wire logic [cws_pkg::DayW-1:0]    day_i,
  input  wire logic [cws_pkg::WdayW-1:0]   day_of_week_i,
  input  wire logic [cws_pkg::HourW-1:0]   hours_i,
  input  wire logic [cws_pkg::MinW-1:0]    minutes_i,
  input  wire logic [cws_pkg::SecW-1:0]    seconds_i,
  // result channel
  output      logic                        done_o,
  output      logic                        date_ok_o,
  output      logic                        time_ok_o,
  output      logic [cws_pkg::WdayW-1:0]   computed_weekday_o,
  output      logic [cws_pkg::YearW-1:0]   period_year_o,
  output      logic [cws_pkg::MonthW-1:0]  period_month_o,
  output      logic [cws_pkg::DayW-1:0]    period_day_o,
  output      logic [cws_pkg::WdayW-1:0]   period_weekday_o,
  output      logic [cws_pkg::HourW-1:0]   period_hour_o,
  output      logic [cws_pkg::DelayW-1:0]  wake_delay_seconds_o,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cws_pkg::AddrW-1:0]   paddr,
  input  wire logic [cws_pkg::DataW-1:0]   pwdata,
  output      logic [cws_pkg::DataW-1:0]   prdata,
  output      logic                        pready
);
  import cws_pkg::*;

  // ---------------------------------------------------------------- registers
  logic              cadence_q;
  logic [HourW-1:0]  start_hr_q;
  logic [HourW-1:0]  end_hr_q;
  logic              cfg_wr;
  cws_reg_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cws_reg_e'(paddr[3:2]);

  // Write a register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cadence_q  <= CadenceRst;
      start_hr_q <= DeskStartRst;
      end_hr_q   <= DeskEndRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CADENCE:    cadence_q  <= pwdata[0];
        REG_DESK_START: start_hr_q <= pwdata[HourW-1:0];
        REG_DESK_END:   end_hr_q   <= pwdata[HourW-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_CADENCE:    prdata = {{(DataW-1){1'b0}}, cadence_q};
      REG_DESK_START: prdata = {{(DataW-HourW){1'b0}}, start_hr_q};
      REG_DESK_END:   prdata = {{(DataW-HourW){1'b0}}, end_hr_q};
      default:        prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage A
  logic              a_vld_q;
  logic [YearW-1:0]  a_year_q;
  logic [MonthW-1:0] a_month_q;
  logic [DayW-1:0]   a_day_q;
  logic [WdayW-1:0]  a_wd_q;
  logic [HourW-1:0]  a_hour_q;
  logic              a_date_ok_q, a_time_ok_q, a_leap_q;
  logic [11:0]       a_wsum_q;
  logic [ElapsW-1:0] a_hsec_q;
  logic [MsW-1:0]    a_ms_q;
  logic              a_lt_start_q, a_gt_end_q, a_lt_end_q;

  logic              in_acc;
  logic              leap_a, yr_ok_a, mo_ok_a;
  logic [YearW-1:0]  yy_a;
  logic [WdayW-1:0]  wd_a;

  assign in_acc  = start && !busy;
  // Year range excludes every century year, so divisibility by four decides
  assign leap_a  = (year_i[1:0] == 2'b00);
  assign yr_ok_a = (year_i >= YearFirst) && (year_i <= YearLast);
  assign mo_ok_a = (month_i >= 4'd1) && (month_i <= 4'd12);
  assign yy_a    = (month_i < 4'd3) ? year_i - 12'd1 : year_i;
  assign wd_a    = (day_of_week_i == 3'd7) ? 3'd0 : day_of_week_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_acc;
    end
  end

  // Capture the word and the checks that need only the inputs and the configuration registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_year_q     <= year_i;
      a_month_q    <= month_i;
      a_day_q      <= day_i;
      a_wd_q       <= wd_a;
      a_hour_q     <= hours_i;
      a_leap_q     <= leap_a;
      a_date_ok_q  <= yr_ok_a && mo_ok_a && (day_i >= 5'd1) &&
                      (day_i <= month_days(month_i, leap_a));
      a_time_ok_q  <= (hours_i < 5'd24) && (minutes_i < 6'd60) && (seconds_i < 6'd60);
      // Century terms are fixed over the year range: -20 + 5 = -15, i.e. +6 mod 7
      a_wsum_q     <= yy_a + {2'b00, yy_a[11:2]} + 12'(month_offset(month_i)) +
                      12'(day_i) + 12'd6;
      a_hsec_q     <= ElapsW'(hours_i) * ElapsW'(SecsPerHour);
      a_ms_q       <= MsW'(minutes_i) * MsW'(60) + MsW'(seconds_i);
      a_lt_start_q <= hours_i < start_hr_q;
      a_gt_end_q   <= hours_i > end_hr_q;
      a_lt_end_q   <= hours_i < end_hr_q;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic              b_vld_q;
  logic              b_date_ok_q, b_time_ok_q;
  logic [WdayW-1:0]  b_cw_q;
  logic [YearW-1:0]  b_py_q;
  logic [MonthW-1:0] b_pm_q;
  logic [DayW-1:0]   b_pd_q;
  logic [WdayW-1:0]  b_pw_q;
  logic [HourW-1:0]  b_ph_q;
  logic [ElapsW-1:0] b_el_q;
  logic [MsW-1:0]    b_ms_q;
  logic              b_lt_start_q, b_lt_end_q;

  logic [YearW-1:0]  py_b;
  logic [MonthW-1:0] pm_b, pm_prev;
  logic [DayW-1:0]   pd_b;
  logic [WdayW-1:0]  pw_b;
  logic [HourW-1:0]  ph_b;

  // Previous month; leap matters only when stepping back into February
  assign pm_prev = (a_month_q == 4'd1) ? 4'd12 : a_month_q - 4'd1;

  // Pick the period date and hour
  always_comb begin
    py_b = a_year_q;
    pm_b = a_month_q;
    pd_b = a_day_q;
    pw_b = a_wd_q;
    ph_b = a_hour_q;
    if (cadence_q && a_lt_start_q) begin
      ph_b = end_hr_q;
      if (a_date_ok_q) begin
        if (a_day_q > 5'd1) begin
          pd_b = a_day_q - 5'd1;
        end else begin
          pm_b = pm_prev;
          pd_b = month_days(pm_prev, a_leap_q);
          if (a_month_q == 4'd1) begin
            py_b = a_year_q - 12'd1;
          end
        end
        pw_b = (a_wd_q == 3'd0) ? 3'd6 : a_wd_q - 3'd1;
      end
    end else if (cadence_q && a_gt_end_q) begin
      ph_b = end_hr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  // Advance the period, weekday and elapsed seconds
  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_date_ok_q  <= a_date_ok_q;
      b_time_ok_q  <= a_time_ok_q;
      b_cw_q       <= a_date_ok_q ? mod7_12(a_wsum_q) : 3'd0;
      b_py_q       <= py_b;
      b_pm_q       <= pm_b;
      b_pd_q       <= pd_b;
      b_pw_q       <= pw_b;
      b_ph_q       <= ph_b;
      b_el_q       <= a_hsec_q + ElapsW'(a_ms_q);
      b_ms_q       <= a_ms_q;
      b_lt_start_q <= a_lt_start_q;
      b_lt_end_q   <= a_lt_end_q;
    end
  end

  // ---------------------------------------------------------------- stage C
  logic              c_vld_q;
  logic [17:0]       start_sec, el_w, delay_c;

  assign start_sec = 18'(start_hr_q) * SecsPerHour;
  assign el_w      = 18'(b_el_q);

  // Select the wake delay for the schedule mode
  always_comb begin
    if (!b_time_ok_q) begin
      delay_c = '0;
    end else if (!cadence_q) begin
      delay_c = SecsPerDay - el_w + WakeMargin;
    end else if (b_lt_start_q) begin
      delay_c = start_sec - el_w + WakeMargin;
    end else if (b_lt_end_q) begin
      delay_c = SecsPerHour - 18'(b_ms_q) + WakeMargin;
    end else begin
      delay_c = SecsPerDay - el_w + start_sec + WakeMargin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  // Hold the result word for its strobe cycle
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      date_ok_o            <= b_date_ok_q;
      time_ok_o            <= b_time_ok_q;
      computed_weekday_o   <= b_cw_q;
      period_year_o        <= b_py_q;
      period_month_o       <= b_pm_q;
      period_day_o         <= b_pd_q;
      period_weekday_o     <= b_pw_q;
      period_hour_o        <= b_ph_q;
      wake_delay_seconds_o <= delay_c[DelayW-1:0];
    end
  end

  assign done_o = c_vld_q;

endmodule

`default_nettype wire

// ----- rtl/core/cws_checker.sv -----
// Port-level checker for the wake scheduler, bound to the top level.
`default_nettype none

module cws_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic                        date_ok_o,
  input wire logic                        time_ok_o,
  input wire logic [cws_pkg::WdayW-1:0]   computed_weekday_o,
  input wire logic [cws_pkg::MonthW-1:0]  period_month_o,
  input wire logic [cws_pkg::DelayW-1:0]  wake_delay_seconds_o
);
  import cws_pkg::*;

  // Each taken word yields a result strobe on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after a taken word");

  // No result strobe without a taken word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##3 !done_o)
    else $error("result strobe without a taken word");

  // Invalid time gives no delay; valid time always gives at least the margin
  a_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((time_ok_o && wake_delay_seconds_o >= 17'd6 &&
                 wake_delay_seconds_o <= 17'd111605) ||
                (!time_ok_o && wake_delay_seconds_o == '0)))
    else $error("wake delay inconsistent with time check");

  // Invalid date gives weekday zero, valid date a proper weekday and month
  a_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((!date_ok_o && computed_weekday_o == 3'd0) ||
                (date_ok_o && computed_weekday_o <= 3'd6 &&
                 period_month_o >= 4'd1 && period_month_o <= 4'd12)))
    else $error("weekday or period month inconsistent with date check");

endmodule

bind calendar_wake_schedule cws_checker u_cws_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .start                (start),
  .busy                 (busy),
  .done_o               (done_o),
  .date_ok_o            (date_ok_o),
  .time_ok_o            (time_ok_o),
  .computed_weekday_o   (computed_weekday_o),
  .period_month_o       (period_month_o),
  .wake_delay_seconds_o (wake_delay_seconds_o)
);

`default_nettype wire

// ----- test/tb_calendar_wake_schedule.sv -----
// Self-checking testbench for the calendar wake scheduler: calendar checks, period and delay.
module tb_calendar_wake_schedule;
  timeunit 1ns;
  timeprecision 1ps;

  import cws_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int RstCycles    = 11;
  localparam int NumSettings  = 11;
  localparam int RandPerPhase = 145;
  localparam int TailCycles   = 12;
  localparam int CycleLimit   = 200000;
  localparam int MaxReports   = 10;
  localparam int DaySecs      = 86400;
  localparam int HourSecs     = 3600;
  localparam int MarginSecs   = 5;
  localparam int FirstYear    = 2024;
  localparam int LastYear     = 2099;

  // One command word as the ports carry it
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [WdayW-1:0]  dow;
    logic [HourW-1:0]  hours;
    logic [MinW-1:0]   minutes;
    logic [SecW-1:0]   seconds;
  } cal_word_t;

  // One result word in port order
  typedef struct packed {
    logic              date_ok;
    logic              time_ok;
    logic [WdayW-1:0]  weekday;
    logic [YearW-1:0]  pyear;
    logic [MonthW-1:0] pmonth;
    logic [DayW-1:0]   pday;
    logic [WdayW-1:0]  pweekday;
    logic [HourW-1:0]  phour;
    logic [DelayW-1:0] delay;
  } wake_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              start         = 1'b0;
  logic              busy;
  logic [YearW-1:0]  year_i        = '0;
  logic [MonthW-1:0] month_i       = '0;
  logic [DayW-1:0]   day_i         = '0;
  logic [WdayW-1:0]  day_of_week_i = '0;
  logic [HourW-1:0]  hours_i       = '0;
  logic [MinW-1:0]   minutes_i     = '0;
  logic [SecW-1:0]   seconds_i     = '0;

  logic              done_o;
  logic              date_ok_o;
  logic              time_ok_o;
  logic [WdayW-1:0]  computed_weekday_o;
  logic [YearW-1:0]  period_year_o;
  logic [MonthW-1:0] period_month_o;
  logic [DayW-1:0]   period_day_o;
  logic [WdayW-1:0]  period_weekday_o;
  logic [HourW-1:0]  period_hour_o;
  logic [DelayW-1:0] wake_delay_seconds_o;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [DataW-1:0]  pwdata  = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Shadow copy of the registers, as last written
  logic              hourly_cfg = CadenceRst;
  logic [HourW-1:0]  start_cfg  = DeskStartRst;
  logic [HourW-1:0]  end_cfg    = DeskEndRst;

  cal_word_t    pending_q [$];
  wake_result_t schedule_q [$];

  int burst_left     = 0;
  int gap_left       = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int words_taken    = 0;
  int results_seen   = 0;
  int bad_dates      = 0;
  int bad_times      = 0;
  int stepped_back   = 0;
  int settings_run   = 0;

  calendar_wake_schedule uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .year_i              (year_i),
    .month_i             (month_i),
    .day_i               (day_i),
    .day_of_week_i       (day_of_week_i),
    .hours_i             (hours_i),
    .minutes_i           (minutes_i),
    .seconds_i           (seconds_i),
    .done_o              (done_o),
    .date_ok_o           (date_ok_o),
    .time_ok_o           (time_ok_o),
    .computed_weekday_o  (computed_weekday_o),
    .period_year_o       (period_year_o),
    .period_month_o      (period_month_o),
    .period_day_o        (period_day_o),
    .period_weekday_o    (period_weekday_o),
    .period_hour_o       (period_hour_o),
    .wake_delay_seconds_o(wake_delay_seconds_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Free-running clock
  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Gregorian month length; m in 1..12
  function automatic int month_length(int y, int m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:           return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Weekday of a valid date by the month offset table, 0 is Sunday
  function automatic int calc_weekday(int y, int m, int d);
    int yy;
    int shift;
    yy = (m < 3) ? y - 1 : y;
    case (m)
      1, 5:    shift = 0;
      2, 6:    shift = 3;
      3, 11:   shift = 2;
      4, 7:    shift = 5;
      8:       shift = 1;
      9:       shift = 4;
      10:      shift = 6;
      default: shift = 4;
    endcase
    return (yy + yy / 4 - yy / 100 + yy / 400 + shift + d) % 7;
  endfunction

  // Expected result of one word under the given register values
  function automatic wake_result_t predict_schedule(cal_word_t w, logic hourly,
                                                    logic [HourW-1:0] st_h,
                                                    logic [HourW-1:0] en_h);
    wake_result_t r;
    int y, m, d, wd, h, mi, s, st, en;
    int py, pm, pd, pw, ph, el, delay, cw;
    bit dok, tok;
    y  = int'(w.year);
    m  = int'(w.month);
    d  = int'(w.day);
    wd = int'(w.dow) % 7;
    h  = int'(w.hours);
    mi = int'(w.minutes);
    s  = int'(w.seconds);
    st = int'(st_h);
    en = int'(en_h);
    tok = (h < 24) && (mi < 60) && (s < 60);
    dok = 1'b0;
    if (y >= FirstYear && y <= LastYear && m >= 1 && m <= 12)
      dok = (d >= 1) && (d <= month_length(y, m));
    cw = dok ? calc_weekday(y, m, d) : 0;
    py = y;
    pm = m;
    pd = d;
    pw = wd;
    ph = h;
    // Hourly window: fall back before the start, clamp after the end
    if (hourly) begin
      if (h < st) begin
        ph = en;
        if (dok) begin
          if (d > 1) begin
            pd = d - 1;
          end else begin
            if (m > 1) begin
              pm = m - 1;
            end else begin
              pm = 12;
              py = y - 1;
            end
            pd = month_length(py, pm);
          end
          pw = (wd + 6) % 7;
        end
      end else if (h > en) begin
        ph = en;
      end
    end
    delay = 0;
    if (tok) begin
      el = h * HourSecs + mi * 60 + s;
      if (hourly) begin
        if (h < st)
          delay = st * HourSecs - el + MarginSecs;
        else if (h < en)
          delay = HourSecs - (el % HourSecs) + MarginSecs;
        else
          delay = DaySecs - el + st * HourSecs + MarginSecs;
      end else begin
        delay = DaySecs - el + MarginSecs;
      end
    end
    r.date_ok  = dok;
    r.time_ok  = tok;
    r.weekday  = WdayW'(cw);
    r.pyear    = YearW'(py);
    r.pmonth   = MonthW'(pm);
    r.pday     = DayW'(pd);
    r.pweekday = WdayW'(pw);
    r.phour    = HourW'(ph);
    r.delay    = DelayW'(delay);
    return r;
  endfunction

  function automatic string show_schedule(wake_result_t r);
    return $sformatf(
      "date_ok=%0d time_ok=%0d wday=%0d period=%0d-%0d-%0d pwday=%0d hour=%0d delay=%0d",
      r.date_ok, r.time_ok, r.weekday, r.pyear, r.pmonth, r.pday,
      r.pweekday, r.phour, r.delay);
  endfunction

  function automatic cal_word_t make_word(int y, int m, int d, int wd, int h, int mi, int s);
    cal_word_t w;
    w.year    = YearW'(y);
    w.month   = MonthW'(m);
    w.day     = DayW'(d);
    w.dow     = WdayW'(wd);
    w.hours   = HourW'(h);
    w.minutes = MinW'(mi);
    w.seconds = SecW'(s);
    return w;
  endfunction

  // Random word: mostly well-formed dates, hours often near the window edges, some noise
  function automatic cal_word_t random_word(int st, int en);
    cal_word_t w;
    logic [63:0] raw;
    int kind, y, m, d, wd, h, mi, s, len;
    int picks [8];
    kind = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (kind < 20) begin
      w = raw[$bits(cal_word_t)-1:0];
    end else begin
      y = ($urandom_range(0, 19) == 0) ? $urandom_range(FirstYear - 4, LastYear + 4)
                                       : $urandom_range(FirstYear, LastYear);
      m = $urandom_range(1, 12);
      len = month_length(y, m);
      case ($urandom_range(0, 3))
        0:       d = 1;
        1:       d = len;
        default: d = $urandom_range(1, len);
      endcase
      wd = ($urandom_range(0, 4) != 0) ? calc_weekday(y, m, d) : $urandom_range(0, 7);
      picks = '{st - 1, st, st + 1, en - 1, en, en + 1, 0, 23};
      if ($urandom_range(0, 4) < 2) begin
        h = picks[$urandom_range(0, 7)];
        if (h < 0) h = 0;
        if (h > 23) h = 23;
      end else begin
        h = $urandom_range(0, 23);
      end
      mi = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
      s  = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
      w = make_word(y, m, d, wd, h, mi, s);
      // Break one field now and then
      if (kind < 30) begin
        case ($urandom_range(0, 6))
          0: w.year    = raw[YearW-1:0];
          1: w.month   = raw[MonthW-1:0];
          2: w.day     = raw[DayW-1:0];
          3: w.dow     = raw[WdayW-1:0];
          4: w.hours   = raw[HourW-1:0];
          5: w.minutes = raw[MinW-1:0];
          default: w.seconds = raw[SecW-1:0];
        endcase
      end
    end
    return w;
  endfunction

  // Edges of every field, leap days, month and year wrap on the step back
  task automatic queue_directed();
    pending_q.push_back(make_word(2024,  1,  1, 1,  0,  0,  0));
    pending_q.push_back(make_word(2099, 12, 31, 4, 23, 59, 59));
    pending_q.push_back(make_word(2023, 12, 31, 0, 12,  0,  0));
    pending_q.push_back(make_word(2100,  1,  1, 5, 12,  0,  0));
    pending_q.push_back(make_word(   0,  0,  0, 0,  0,  0,  0));
    pending_q.push_back(make_word(4095, 15, 31, 7, 31, 63, 63));
    pending_q.push_back(make_word(2024,  2, 29, 4,  6, 30,  0));
    pending_q.push_back(make_word(2025,  2, 29, 6,  6,  0,  0));
    pending_q.push_back(make_word(2096,  2, 29, 3, 10,  0,  0));
    pending_q.push_back(make_word(2025,  3,  1, 6,  5,  0,  0));
    pending_q.push_back(make_word(2024,  3,  1, 5,  2,  0,  0));
    pending_q.push_back(make_word(2024,  5,  1, 3,  3,  0,  0));
    pending_q.push_back(make_word(2024,  4, 31, 3,  3,  0,  0));
    pending_q.push_back(make_word(2024, 13,  1, 0,  8,  0,  0));
    pending_q.push_back(make_word(2024,  0,  5, 0,  8,  0,  0));
    pending_q.push_back(make_word(2024,  6,  0, 0,  8,  0,  0));
    pending_q.push_back(make_word(2024,  7,  4, 7,  1,  0,  0));
    pending_q.push_back(make_word(2024,  9,  1, 0,  4,  0,  0));
    pending_q.push_back(make_word(2024, 10, 15, 2,  7,  0,  0));
    pending_q.push_back(make_word(2024, 10, 15, 2, 19,  0,  0));
    pending_q.push_back(make_word(2024, 10, 15, 2, 20, 30, 30));
    pending_q.push_back(make_word(2024, 10, 15, 2, 24,  0,  0));
    pending_q.push_back(make_word(2024, 10, 15, 2, 12, 60,  0));
    pending_q.push_back(make_word(2024, 10, 15, 2, 12,  0, 63));
    pending_q.push_back(make_word(2024, 11, 30, 6, 18, 59, 59));
  endtask

  // One register write: setup cycle, then access until pready
  task automatic write_reg(cws_reg_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CADENCE:    hourly_cfg = val[0];
      REG_DESK_START: start_cfg  = val[HourW-1:0];
      REG_DESK_END:   end_cfg    = val[HourW-1:0];
      default:        ;
    endcase
  endtask

  task automatic apply_settings(logic hourly, int st, int en);
    write_reg(REG_CADENCE, DataW'(hourly));
    write_reg(REG_DESK_START, DataW'(st));
    write_reg(REG_DESK_END, DataW'(en));
  endtask

  // Hold until every word is sent and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i); while (pending_q.size() != 0 || start || schedule_q.size() != 0);
  endtask

  // Sequence the register settings and fill the word queue
  initial begin
    int st, en;
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: apply_settings(1'b1, 7, 19);
          2: apply_settings(1'b1, 0, 23);
          3: apply_settings(1'b1, 23, 0);
          4: apply_settings(1'b1, 0, 0);
          5: apply_settings(1'b1, 23, 23);
          6: apply_settings(1'b0, $urandom_range(0, 23), $urandom_range(0, 23));
          10: apply_settings(1'b1, $urandom_range(0, 23), $urandom_range(0, 23));
          default: begin
            st = $urandom_range(0, 22);
            en = $urandom_range(st + 1, 23);
            apply_settings(1'b1, st, en);
          end
        endcase
      end
      settings_run++;
      if (p < 2) queue_directed();
      repeat (RandPerPhase) pending_q.push_back(random_word(int'(start_cfg), int'(end_cfg)));
    end
    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    $display("Checked %0d results from %0d words under %0d register settings",
             results_seen, words_taken, settings_run);
    $display("Invalid dates %0d, invalid times %0d, hourly step-backs %0d",
             bad_dates, bad_times, stepped_back);
    if (mismatches == 0 && schedule_q.size() == 0) begin
      $display("calendar_wake_schedule test passed");
    end else begin
      $display("calendar_wake_schedule test failed");
    end
    $finish;
  end

  // Send words in bursts with random gaps; hold a word until it is taken
  always @(posedge clk_i or negedge rst_ni) begin : send_words
    cal_word_t nxt;
    logic      drive;
    if (!rst_ni) begin
      start      <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else if (!start || !busy) begin
      drive = 1'b0;
      nxt   = '0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        nxt   = pending_q.pop_front();
        drive = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= drive;
      if (drive) begin
        year_i        <= nxt.year;
        month_i       <= nxt.month;
        day_i         <= nxt.day;
        day_of_week_i <= nxt.dow;
        hours_i       <= nxt.hours;
        minutes_i     <= nxt.minutes;
        seconds_i     <= nxt.seconds;
      end
    end
  end

  // Predict each taken word and check each result strobe against the oldest
  always @(posedge clk_i) begin : check_results
    cal_word_t    taken;
    wake_result_t want, got;
    string        bad;
    if (rst_ni) begin
      if (start && !busy) begin
        taken = {year_i, month_i, day_i, day_of_week_i, hours_i, minutes_i, seconds_i};
        want  = predict_schedule(taken, hourly_cfg, start_cfg, end_cfg);
        schedule_q.push_back(want);
        words_taken++;
        if (!want.date_ok) bad_dates++;
        if (!want.time_ok) bad_times++;
        if (hourly_cfg && want.date_ok && taken.hours < start_cfg) stepped_back++;
      end
      if (done_o) begin
        got = {date_ok_o, time_ok_o, computed_weekday_o, period_year_o, period_month_o,
               period_day_o, period_weekday_o, period_hour_o, wake_delay_seconds_o};
        results_seen++;
        if (schedule_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("Result with no word outstanding: %s", show_schedule(got));
        end else begin
          want = schedule_q.pop_front();
          bad  = "";
          if (got.date_ok  !== want.date_ok)  bad = {bad, " date_ok"};
          if (got.time_ok  !== want.time_ok)  bad = {bad, " time_ok"};
          if (got.weekday  !== want.weekday)  bad = {bad, " computed_weekday"};
          if (got.pyear    !== want.pyear)    bad = {bad, " period_year"};
          if (got.pmonth   !== want.pmonth)   bad = {bad, " period_month"};
          if (got.pday     !== want.pday)     bad = {bad, " period_day"};
          if (got.pweekday !== want.pweekday) bad = {bad, " period_weekday"};
          if (got.phour    !== want.phour)    bad = {bad, " period_hour"};
          if (got.delay    !== want.delay)    bad = {bad, " wake_delay_seconds"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("Mismatch in%s at result %0d", bad, results_seen);
              $display("  expected %s", show_schedule(want));
              $display("  actual   %s", show_schedule(got));
            end
          end
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               schedule_q.size());
      $display("calendar_wake_schedule test failed");
      $finish;
    end
  end

endmodule
